/* sv/pprr_pkg.sv */
// Shared types and constants for the priority/round-robin scheduler.
// No dependencies; the files that use it refer to it by scoped names.
package pprr_pkg;

  localparam int LEVEL_W     = 8;
  localparam int SLICE_W     = 8;
  localparam int SLICE_RESET = 4;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_FREAD  = 6'b001000,
    S_EXEC   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic arrive;
    logic decide;
    logic fifo_load;
    logic exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic need_fifo_read;
    logic out_free;
  } status_t;

endpackage

/* sv/pprr_ifs.sv */
// Valid/ready channel interfaces for the scheduler's input and result beats.
// Uses pprr_pkg for the fixed level width.
interface pprr_in_if #(
  parameter int ID_BITS     = 8,
  parameter int LENGTH_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ID_BITS-1:0]           job_id;
  logic [LENGTH_BITS-1:0]       job_length;
  logic [pprr_pkg::LEVEL_W-1:0] job_level;

  modport source (output valid, kind, job_id, job_length, job_level, input ready);
  modport sink   (input valid, kind, job_id, job_length, job_level, output ready);
endinterface

interface pprr_out_if #(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               ran_valid;
  logic [ID_BITS-1:0] ran_id;
  logic               finished;
  logic               requeued;

  modport source (output valid, accepted, ran_valid, ran_id, finished, requeued,
                  input ready);
  modport sink   (input valid, accepted, ran_valid, ran_id, finished, requeued,
                  output ready);
endinterface

/* sv/pprr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pprr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* sv/pprr_ctrl.sv */
// Scheduler sequencer: each beat enters scan; ticks also decide and execute.
// Depends on pprr_pkg for the state, command and status types.
module pprr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pprr_pkg::status_t   status,
  output pprr_pkg::cmd_t      cmd
);
  pprr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pprr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      pprr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = pprr_pkg::S_SCAN;
        end
      end
      pprr_pkg::S_SCAN: begin
        if (!status.is_tick) begin
          cmd.arrive = 1'b1;
          state_nxt  = pprr_pkg::S_DONE;
        end else if (status.scan_done) begin
          state_nxt = pprr_pkg::S_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      pprr_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.need_fifo_read ? pprr_pkg::S_FREAD : pprr_pkg::S_EXEC;
      end
      pprr_pkg::S_FREAD: begin
        cmd.fifo_load = 1'b1;
        state_nxt     = pprr_pkg::S_EXEC;
      end
      pprr_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = pprr_pkg::S_DONE;
      end
      pprr_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pprr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pprr_pkg::S_IDLE;
      end
    endcase
  end
endmodule

/* sv/pprr_dp.sv */
// Datapath: job pool, round-robin FIFO, running-job registers and result beat.
// Depends on pprr_pkg and pprr_ram.
module pprr_dp #(
  parameter int MAX_JOBS    = 16,
  parameter int ID_BITS     = 8,
  parameter int LENGTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pprr_pkg::cmd_t                cmd,
  output pprr_pkg::status_t             status,
  input  logic                          in_kind,
  input  logic [ID_BITS-1:0]            in_job_id,
  input  logic [LENGTH_BITS-1:0]        in_job_length,
  input  logic [pprr_pkg::LEVEL_W-1:0]  in_job_level,
  input  logic                          cfg_we,
  input  logic [pprr_pkg::SLICE_W-1:0]  cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_ran_valid,
  output logic [ID_BITS-1:0]            out_ran_id,
  output logic                          out_finished,
  output logic                          out_requeued
);
  localparam int IDX_W  = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int LVL_W  = pprr_pkg::LEVEL_W;
  localparam int SL_W   = pprr_pkg::SLICE_W;
  localparam int POOL_W = ID_BITS + LVL_W + LENGTH_BITS;
  localparam int FIFO_W = ID_BITS + LENGTH_BITS;

  // configuration
  logic [SL_W-1:0] time_slice_r;

  // latched input beat
  logic                   kind_r;
  logic [ID_BITS-1:0]     id_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LVL_W-1:0]       lvl_r;

  // pool bookkeeping
  logic [MAX_JOBS-1:0] pool_valid_r;
  logic [CNT_W-1:0]    pool_cnt_r;

  // scan
  logic [CNT_W-1:0]       scan_idx_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pidx_r;
  logic                   best_found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [ID_BITS-1:0]     best_id_r;
  logic [LVL_W-1:0]       best_lvl_r;
  logic [LENGTH_BITS-1:0] best_left_r;

  // fifo pointers
  logic [IDX_W-1:0] fifo_head_r;
  logic [IDX_W-1:0] fifo_tail_r;
  logic [CNT_W-1:0] fifo_cnt_r;

  // running job
  logic                   run_busy_r;
  logic                   run_from_fifo_r;
  logic [ID_BITS-1:0]     run_id_r;
  logic [LVL_W-1:0]       run_level_r;
  logic [LENGTH_BITS-1:0] run_left_r;
  logic [SL_W-1:0]        slice_left_r;

  // result beat
  logic               res_accepted_r;
  logic               res_ran_valid_r;
  logic [ID_BITS-1:0] res_ran_id_r;
  logic               res_finished_r;
  logic               res_requeued_r;
  logic               out_valid_r;
  logic               out_accepted_r;
  logic               out_ran_valid_r;
  logic [ID_BITS-1:0] out_ran_id_r;
  logic               out_finished_r;
  logic               out_requeued_r;

  // ---------------- pool RAM ----------------
  logic                   pool_we;
  logic                   pool_re;
  logic [IDX_W-1:0]       free_slot;
  logic                   free_found;
  logic [POOL_W-1:0]      pool_rdata;
  logic [ID_BITS-1:0]     e_id;
  logic [LVL_W-1:0]       e_lvl;
  logic [LENGTH_BITS-1:0] e_left;
  logic [CNT_W:0]         used;
  logic                   arr_ok;
  logic                   better;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = MAX_JOBS - 1; k >= 0; k--) begin
      if (!pool_valid_r[k]) begin
        free_found = 1'b1;
        free_slot  = IDX_W'(k);
      end
    end
  end

  assign used   = (CNT_W + 1)'(fifo_cnt_r) + (CNT_W + 1)'(pool_cnt_r)
                + (CNT_W + 1)'(run_busy_r);
  assign arr_ok = (id_r != '0) && (len_r != '0) && free_found
                && (used < (CNT_W + 1)'(MAX_JOBS));
  assign pool_we = cmd.arrive && arr_ok;
  assign pool_re = cmd.scan_step && (scan_idx_r < CNT_W'(MAX_JOBS));

  pprr_ram #(.WIDTH(POOL_W), .DEPTH(MAX_JOBS)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (free_slot),
    .wdata ({id_r, lvl_r, len_r}),
    .re    (pool_re),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (pool_rdata)
  );

  assign {e_id, e_lvl, e_left} = pool_rdata;
  // strict compares keep the lower slot on a full tie
  assign better = pend_r && pool_valid_r[pidx_r]
                && (!best_found_r || (e_lvl < best_lvl_r)
                    || ((e_lvl == best_lvl_r) && (e_id < best_id_r)));

  // ---------------- decide / exec ----------------
  logic                   preempt;
  logic                   dispatch;
  logic                   fifo_pop;
  logic [LENGTH_BITS-1:0] left_dec;
  logic [SL_W-1:0]        slice_dec;
  logic                   exec_fin;
  logic                   exec_req;
  logic                   fifo_we;
  logic [FIFO_W-1:0]      fifo_wdata;
  logic [FIFO_W-1:0]      fifo_rdata;

  assign preempt  = run_busy_r && best_found_r && (run_from_fifo_r || (best_lvl_r < run_level_r));
  assign dispatch = cmd.decide && best_found_r && (!run_busy_r || preempt);
  assign fifo_pop = !run_busy_r && !best_found_r && (fifo_cnt_r != '0);

  assign left_dec  = run_left_r - LENGTH_BITS'(1);
  assign slice_dec = slice_left_r - SL_W'(1);
  assign exec_fin  = run_busy_r && (left_dec == '0);
  assign exec_req  = run_busy_r && !exec_fin && (slice_dec == '0);

  assign fifo_we    = ((cmd.decide && preempt) || (cmd.exec && exec_req))
                    && (fifo_cnt_r < CNT_W'(MAX_JOBS));
  assign fifo_wdata = cmd.exec ? {run_id_r, left_dec} : {run_id_r, run_left_r};

  pprr_ram #(.WIDTH(FIFO_W), .DEPTH(MAX_JOBS)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_tail_r),
    .wdata (fifo_wdata),
    .re    (cmd.decide),
    .raddr (fifo_head_r),
    .rdata (fifo_rdata)
  );

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == IDX_W'(MAX_JOBS - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      id_r   <= in_job_id;
      len_r  <= in_job_length;
      lvl_r  <= in_job_level;
    end
    if (better) begin
      best_idx_r  <= pidx_r;
      best_id_r   <= e_id;
      best_lvl_r  <= e_lvl;
      best_left_r <= e_left;
    end
    if (pool_re) begin
      pidx_r <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.arrive) begin
      res_accepted_r  <= arr_ok;
      res_ran_valid_r <= 1'b0;
      res_ran_id_r    <= '0;
      res_finished_r  <= 1'b0;
      res_requeued_r  <= 1'b0;
    end else if (cmd.exec) begin
      res_accepted_r  <= 1'b0;
      res_ran_valid_r <= run_busy_r;
      res_ran_id_r    <= run_busy_r ? run_id_r : '0;
      res_finished_r  <= exec_fin;
      res_requeued_r  <= exec_req;
    end
    if (cmd.out_load) begin
      out_accepted_r  <= res_accepted_r;
      out_ran_valid_r <= res_ran_valid_r;
      out_ran_id_r    <= res_ran_id_r;
      out_finished_r  <= res_finished_r;
      out_requeued_r  <= res_requeued_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_slice_r    <= SL_W'(pprr_pkg::SLICE_RESET);
      pool_valid_r    <= '0;
      pool_cnt_r      <= '0;
      scan_idx_r      <= '0;
      pend_r          <= 1'b0;
      best_found_r    <= 1'b0;
      fifo_head_r     <= '0;
      fifo_tail_r     <= '0;
      fifo_cnt_r      <= '0;
      run_busy_r      <= 1'b0;
      run_from_fifo_r <= 1'b0;
      run_id_r        <= '0;
      run_level_r     <= '1;
      run_left_r      <= '0;
      slice_left_r    <= SL_W'(pprr_pkg::SLICE_RESET);
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_slice_r <= cfg_wdata;
      end

      // scan sequencing
      if (cmd.scan_start) begin
        scan_idx_r   <= '0;
        pend_r       <= 1'b0;
        best_found_r <= 1'b0;
      end else begin
        pend_r <= pool_re;
        if (pool_re) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (better) begin
          best_found_r <= 1'b1;
        end
      end

      // pool store
      if (pool_we) begin
        pool_valid_r[free_slot] <= 1'b1;
        pool_cnt_r              <= pool_cnt_r + CNT_W'(1);
      end else if (dispatch) begin
        pool_valid_r[best_idx_r] <= 1'b0;
        pool_cnt_r               <= pool_cnt_r - CNT_W'(1);
      end

      // fifo pointers: push and pop never share a cycle
      if (fifo_we) begin
        fifo_tail_r <= ptr_inc(fifo_tail_r);
        fifo_cnt_r  <= fifo_cnt_r + CNT_W'(1);
      end else if (cmd.fifo_load) begin
        fifo_head_r <= ptr_inc(fifo_head_r);
        fifo_cnt_r  <= fifo_cnt_r - CNT_W'(1);
      end

      // running job
      if (dispatch) begin
        run_busy_r      <= 1'b1;
        run_from_fifo_r <= 1'b0;
        run_id_r        <= best_id_r;
        run_level_r     <= best_lvl_r;
        run_left_r      <= best_left_r;
        slice_left_r    <= time_slice_r;
      end else if (cmd.fifo_load) begin
        run_busy_r                <= 1'b1;
        run_from_fifo_r           <= 1'b1;
        {run_id_r, run_left_r}    <= fifo_rdata;
        run_level_r               <= '1;
        slice_left_r              <= time_slice_r;
      end else if (cmd.exec && run_busy_r) begin
        slice_left_r <= exec_fin ? time_slice_r : slice_dec;
        if (exec_fin || exec_req) begin
          run_busy_r      <= 1'b0;
          run_from_fifo_r <= 1'b0;
          run_id_r        <= '0;
          run_level_r     <= '1;
          run_left_r      <= '0;
        end else begin
          run_left_r <= left_dec;
        end
      end

      // result register
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.is_tick        = kind_r;
  assign status.scan_done      = (scan_idx_r == CNT_W'(MAX_JOBS)) && !pend_r;
  assign status.need_fifo_read = fifo_pop;
  assign status.out_free       = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_accepted  = out_accepted_r;
  assign out_ran_valid = out_ran_valid_r;
  assign out_ran_id    = out_ran_id_r;
  assign out_finished  = out_finished_r;
  assign out_requeued  = out_requeued_r;

  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (CNT_W + 1)'(MAX_JOBS))
    else $error("job store holds more than its capacity");

  a_fifo_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt_r == '0) |-> (fifo_head_r == fifo_tail_r))
    else $error("empty fifo with head and tail apart");

  a_finish_xor_requeue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !(res_finished_r && res_requeued_r))
    else $error("tick reported both finished and requeued");

  a_dispatch_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dispatch |-> pool_valid_r[best_idx_r])
    else $error("dispatch from an empty pool slot");
endmodule

/* sv/priority_preempt_round_robin_scheduler_top.sv */
// Top level of the preemptive priority scheduler with round-robin requeue.
// Depends on pprr_pkg, pprr_ifs, pprr_ctrl, pprr_dp and pprr_ram.
//
// Each input beat is a job arrival (kind 0) or one tick of execution (kind 1),
// and each produces exactly one result beat. A new beat is taken only after
// the previous result is loaded. An arrival is checked and stored in the scan
// state and loaded as a result from the done state. A tick scans the pool,
// decides, reads the round-robin FIFO when the job comes from it, executes and
// loads its result: the pool RAM is read one entry per cycle to find the most
// urgent waiting job (lowest level, then lowest id, then lowest slot) through
// its single read port.
// A running pool job is displaced only by a pool job of strictly lower
// level; a FIFO job is displaced by any pool job; displaced and slice-expired
// jobs go to the FIFO tail. The next beat is accepted while a finished
// result still waits in the output register. Write time_slice through
// cfg_we/cfg_wdata only while the block is idle; a value of 0 grants 256
// ticks. Job ids and lengths of zero are rejected.
module priority_preempt_round_robin_scheduler_top #(
  parameter int MAX_JOBS    = 16,
  parameter int ID_BITS     = 8,
  parameter int LENGTH_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pprr_in_if.sink                      in_beat,
  pprr_out_if.source                   out_beat,
  input  logic                         cfg_we,
  input  logic [pprr_pkg::SLICE_W-1:0] cfg_wdata
);
  pprr_pkg::cmd_t    cmd;
  pprr_pkg::status_t status;

  // sequence each beat: scan, then for a tick decide, fetch, execute, and hand off
  pprr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_beat.valid),
    .in_ready (in_beat.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold pool, FIFO, running job and the result register
  pprr_dp #(
    .MAX_JOBS    (MAX_JOBS),
    .ID_BITS     (ID_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_kind       (in_beat.kind),
    .in_job_id     (in_beat.job_id),
    .in_job_length (in_beat.job_length),
    .in_job_level  (in_beat.job_level),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_beat.valid),
    .out_ready     (out_beat.ready),
    .out_accepted  (out_beat.accepted),
    .out_ran_valid (out_beat.ran_valid),
    .out_ran_id    (out_beat.ran_id),
    .out_finished  (out_beat.finished),
    .out_requeued  (out_beat.requeued)
  );
endmodule

/* bench/tb_priority_preempt_round_robin_scheduler_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the priority/round-robin scheduler top level.
// Depends on pprr_pkg, pprr_ifs and the top level; predicts every result beat and compares it.
module tb_priority_preempt_round_robin_scheduler_top;

  localparam int NJOBS = 16;
  localparam int LIMIT = 2000000;
  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic       accepted;
    logic       ran_valid;
    logic [7:0] ran_id;
    logic       finished;
    logic       requeued;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [pprr_pkg::SLICE_W-1:0] cfg_wdata = '0;

  pprr_in_if  #(.ID_BITS(8), .LENGTH_BITS(16)) in_ch ();
  pprr_out_if #(.ID_BITS(8)) out_ch ();

  priority_preempt_round_robin_scheduler_top #(
    .MAX_JOBS(NJOBS), .ID_BITS(8), .LENGTH_BITS(16)
  ) uut (
    .clk(clk), .rst_n(rst_n), .in_beat(in_ch.sink), .out_beat(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the scheduler state.
  logic [7:0]  slice_cfg;
  logic [7:0]  p_id [NJOBS];
  logic [7:0]  p_lvl [NJOBS];
  logic [15:0] p_left [NJOBS];
  logic        p_vld [NJOBS];
  logic [7:0]  q_id [NJOBS];
  logic [15:0] q_left [NJOBS];
  int          q_head, q_tail, q_count;
  logic        busy, from_q;
  logic [7:0]  cur_id, cur_lvl, slice_cnt;
  logic [15:0] cur_left;

  sched_res_t expected_beats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic sched_reset();
    slice_cfg = pprr_pkg::SLICE_RESET;
    for (int k = 0; k < NJOBS; k++) p_vld[k] = 1'b0;
    q_head = 0; q_tail = 0; q_count = 0;
    busy = 0; from_q = 0; cur_id = 0; cur_lvl = 8'hFF; cur_left = 0;
    slice_cnt = slice_cfg;
  endtask

  task automatic queue_push(logic [7:0] id, logic [15:0] left);
    if (q_count >= NJOBS) return;
    q_id[q_tail] = id; q_left[q_tail] = left;
    q_tail = (q_tail + 1) % NJOBS;
    q_count++;
  endtask

  task automatic take_pool(int k);
    busy = 1; from_q = 0;
    cur_id = p_id[k]; cur_lvl = p_lvl[k]; cur_left = p_left[k];
    p_vld[k] = 1'b0;
    slice_cnt = slice_cfg;
  endtask

  task automatic drop_running();
    busy = 0; from_q = 0; cur_id = 0; cur_lvl = 8'hFF; cur_left = 0;
  endtask

  // Advance the shadow state by one beat and return the result it yields.
  task automatic schedule_beat(input logic kind, input logic [7:0] id,
                               input logic [15:0] len, input logic [7:0] lvl,
                               output sched_res_t r);
    int used, free_k, best;
    r = '0;
    if (kind == KIND_ARRIVE) begin
      used = q_count + (busy ? 1 : 0);
      free_k = -1;
      for (int k = 0; k < NJOBS; k++)
        if (p_vld[k]) used++;
        else if (free_k < 0) free_k = k;
      if (id != 0 && len != 0 && used < NJOBS && free_k >= 0) begin
        p_id[free_k] = id; p_lvl[free_k] = lvl; p_left[free_k] = len;
        p_vld[free_k] = 1'b1;
        r.accepted = 1'b1;
      end
      return;
    end
    best = -1;
    for (int k = 0; k < NJOBS; k++)
      if (p_vld[k] && (best < 0 || p_lvl[k] < p_lvl[best] ||
          (p_lvl[k] == p_lvl[best] && p_id[k] < p_id[best])))
        best = k;
    if (!busy) begin
      if (best >= 0) take_pool(best);
      else if (q_count > 0) begin
        busy = 1; from_q = 1;
        cur_id = q_id[q_head]; cur_left = q_left[q_head]; cur_lvl = 8'hFF;
        q_head = (q_head + 1) % NJOBS;
        q_count--;
        slice_cnt = slice_cfg;
      end
    end else if (best >= 0 && (from_q || p_lvl[best] < cur_lvl)) begin
      queue_push(cur_id, cur_left);
      take_pool(best);
    end
    if (busy) begin
      r.ran_valid = 1'b1;
      r.ran_id = cur_id;
      cur_left = cur_left - 16'd1;
      slice_cnt = slice_cnt - 8'd1;
      if (cur_left == 0) begin
        r.finished = 1'b1;
        drop_running();
        slice_cnt = slice_cfg;
      end else if (slice_cnt == 0) begin
        r.requeued = 1'b1;
        queue_push(cur_id, cur_left);
        drop_running();
      end
    end
  endtask

  // Offer one beat; predict at the accepting edge. Valid stays high after
  // the beat so that a following beat can go out back to back.
  task automatic send_beat(logic kind, logic [7:0] id, logic [15:0] len,
                           logic [7:0] lvl);
    sched_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.job_id <= id;
    in_ch.job_length <= len;
    in_ch.job_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    schedule_beat(kind, id, len, lvl, r);
    expected_beats = {expected_beats, r};
  endtask

  task automatic tick();
    send_beat(KIND_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic arrive(logic [7:0] id, logic [15:0] len, logic [7:0] lvl);
    send_beat(KIND_ARRIVE, id, len, lvl);
  endtask

  // Drop valid, wait for all results, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_cfg = v;
  endtask

  // Receiver: random stalls, plus a long hold when requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    sched_res_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.accepted, out_ch.ran_valid, out_ch.ran_id,
              out_ch.finished, out_ch.requeued};
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    arrive(8'd0, 16'd5, 8'd1);          // id zero rejected
    arrive(8'd1, 16'd0, 8'd1);          // length zero rejected
    tick();                              // nothing to run
    arrive(8'hFF, 16'hFFFF, 8'hFF);
    arrive(8'd7, 16'd3, 8'd0);
    arrive(8'd3, 16'd2, 8'd0);           // tie on level, lower id wins
    arrive(8'd3, 16'd1, 8'd0);           // duplicate id, lower slot wins
    repeat (8) tick();
    arrive(8'd9, 16'd1, 8'd0);           // preempts a lower-priority pool job
    repeat (4) tick();
    for (int k = 1; k <= 18; k++) arrive(8'(k + 20), 16'd2, 8'(k)); // overfill
    repeat (5) tick();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) tick();
      else if ($urandom_range(9) == 0)
        arrive(8'($urandom), 16'($urandom), 8'($urandom));
      else
        arrive(8'($urandom_range(255, 0)), 16'($urandom_range(12, 0)),
               8'($urandom_range(7, 0)));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) if (i % 2) tick(); else arrive(8'(i + 1), 16'd3, 8'd2);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.kind = 1'b0; in_ch.job_id = '0;
    in_ch.job_length = '0; in_ch.job_level = '0; out_ch.ready = 1'b0;
    sched_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7; recv_idle_pct = 73;
    test_directed();
    test_random(200);
    write_slice(8'd1);
    send_idle_pct = 73; recv_idle_pct = 7;
    test_random(200);
    write_slice(8'd0);                   // 256-tick slice
    test_random(150);
    write_slice(8'd255);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    write_slice(8'd3);
    test_random(200);
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
